>>> rtl/indexed_max_heap_top_assert.svh
// Assertion macros for the indexed max-heap block.
`ifndef INDEXED_MAX_HEAP_TOP_ASSERT_SVH
`define INDEXED_MAX_HEAP_TOP_ASSERT_SVH

// Implication checked at every edge outside reset.
`define IMH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define IMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/imh_pkg.sv
`timescale 1ns / 1ps
package imh_pkg;
   localparam int MaxEntries = 1024;
   localparam int PosW       = $clog2(MaxEntries);
   localparam int CntW       = PosW + 1;
   localparam int PrioW      = 32;

   localparam logic [1:0] OpPush   = 2'd0;
   localparam logic [1:0] OpUpdate = 2'd1;
   localparam logic [1:0] OpClear  = 2'd2;

   localparam logic [1:0] StOk     = 2'd0;
   localparam logic [1:0] StFull   = 2'd1;
   localparam logic [1:0] StAbsent = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_KEYRD,      // read key_position
      S_KEYWT,
      S_UPRD,       // read parent
      S_UPWT,
      S_UPCMP,
      S_DNRD,       // read left child
      S_DNWT,
      S_DNCMP,
      S_ROOTRD,
      S_ROOTWT,
      S_DONE
   } state_type;
endpackage

>>> rtl/imh_ram.sv
`timescale 1ns / 1ps
module imh_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> rtl/imh_engine.sv
`timescale 1ns / 1ps
module imh_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              op,
   input  logic [imh_pkg::PosW-1:0]  key_id,
   input  logic [imh_pkg::PrioW-1:0] new_priority,
   input  logic [imh_pkg::CntW-1:0]  limit,
   output logic                    busy,
   output logic                    done,
   output logic [1:0]              status,
   output logic [imh_pkg::PosW-1:0]  top_key,
   output logic [imh_pkg::PrioW-1:0] top_priority,
   output logic [imh_pkg::CntW-1:0]  count
);
   import imh_pkg::*;

   state_type state_ff, state_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [PosW-1:0]  pos_ff, pos_in;       // current position of moving entry
   logic [PosW-1:0]  mkey_ff, mkey_in;     // key of moving entry
   logic [PrioW-1:0] mprio_ff, mprio_in;   // priority of moving entry
   logic             push_ff, push_in;
   logic [1:0]       status_ff, status_in;
   logic [PrioW-1:0] lprio_ff, lprio_in;
   logic [PosW-1:0]  lkey_ff, lkey_in;
   logic [PosW-1:0]  tkey_ff, tkey_in;
   logic [PrioW-1:0] tprio_ff, tprio_in;

   // heap stores: one write and one read port each
   logic             hw_en, kp_we;
   logic [PosW-1:0]  hw_addr, hr_addr, kp_waddr, kp_wdata, kp_raddr, kp_rdata;
   logic [PrioW-1:0] hw_prio, hr_prio;
   logic [PosW-1:0]  hw_key, hr_key;

   imh_ram #(.Width(PrioW), .Depth(MaxEntries)) u_prio (
      .clock(clock), .wr_en(hw_en), .wr_addr(hw_addr), .wr_data(hw_prio),
      .rd_addr(hr_addr), .rd_data(hr_prio));
   imh_ram #(.Width(PosW), .Depth(MaxEntries)) u_key (
      .clock(clock), .wr_en(hw_en), .wr_addr(hw_addr), .wr_data(hw_key),
      .rd_addr(hr_addr), .rd_data(hr_key));
   imh_ram #(.Width(PosW), .Depth(MaxEntries)) u_kpos (
      .clock(clock), .wr_en(kp_we), .wr_addr(kp_waddr), .wr_data(kp_wdata),
      .rd_addr(kp_raddr), .rd_data(kp_rdata));

   logic [PosW-1:0] parent;
   logic [CntW:0]   lc_w, rc_w;
   logic [CntW-1:0] lim;

   assign parent = PosW'((pos_ff - 1'b1) >> 1);
   assign lc_w   = {pos_ff, 1'b1} + (CntW+1)'(0);
   assign rc_w   = (CntW+1)'({pos_ff, 1'b0}) + (CntW+1)'(2);
   assign lim    = (limit < CntW'(MaxEntries)) ? limit : CntW'(MaxEntries);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff <= pos_in;   mkey_ff <= mkey_in;   mprio_ff <= mprio_in;
      push_ff <= push_in; status_ff <= status_in;
      lprio_ff <= lprio_in; lkey_ff <= lkey_in;
      tkey_ff <= tkey_in; tprio_ff <= tprio_in;
   end

   always_comb begin
      state_in = state_ff;   count_in = count_ff;
      pos_in = pos_ff;       mkey_in = mkey_ff;     mprio_in = mprio_ff;
      push_in = push_ff;     status_in = status_ff;
      lprio_in = lprio_ff;   lkey_in = lkey_ff;
      tkey_in = tkey_ff;     tprio_in = tprio_ff;
      hw_en = 1'b0; hw_addr = pos_ff; hw_prio = mprio_ff; hw_key = mkey_ff;
      hr_addr = '0;
      kp_we = 1'b0; kp_waddr = mkey_ff; kp_wdata = pos_ff; kp_raddr = mkey_ff;
      done = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = StOk;
               mprio_in  = new_priority;
               case (op)
                  OpPush: begin
                     if (count_ff >= lim) begin
                        status_in = StFull;
                        state_in  = S_ROOTRD;
                     end else begin
                        pos_in  = PosW'(count_ff);
                        mkey_in = PosW'(count_ff);
                        push_in = 1'b1;
                        count_in = count_ff + 1'b1;
                        state_in = S_UPRD;
                     end
                  end
                  OpUpdate: begin
                     if (CntW'(key_id) >= count_ff) begin
                        status_in = StAbsent;
                        state_in  = S_ROOTRD;
                     end else begin
                        mkey_in  = key_id;
                        push_in  = 1'b0;
                        state_in = S_KEYRD;
                     end
                  end
                  OpClear: begin
                     count_in = '0;
                     state_in = S_ROOTRD;
                  end
                  default: state_in = S_ROOTRD;
               endcase
            end
         end
         S_KEYRD: state_in = S_KEYWT;   // kp_raddr holds the captured key
         S_KEYWT: begin
            pos_in   = kp_rdata;
            state_in = S_UPRD;
         end
         S_UPRD: begin
            if (pos_ff == '0) begin
               state_in = push_ff ? S_DONE : S_DNRD;
            end else begin
               hr_addr  = parent;
               state_in = S_UPWT;
            end
         end
         S_UPWT: begin
            hr_addr  = parent;   // hold the address so the data stays put
            state_in = S_UPCMP;
         end
         S_UPCMP: begin
            // swap while the parent is strictly smaller; a valid heap above
            // a stop point never swaps again, so a push may end here
            if (hr_prio < mprio_ff) begin
               hw_en = 1'b1; hw_addr = pos_ff; hw_prio = hr_prio; hw_key = hr_key;
               kp_we = 1'b1; kp_waddr = hr_key; kp_wdata = pos_ff;
               pos_in   = parent;
               state_in = S_UPRD;
            end else begin
               state_in = push_ff ? S_DONE : S_DNRD;
            end
         end
         S_DNRD: begin
            if (lc_w >= (CntW+1)'(count_ff)) begin
               state_in = S_DONE;
            end else begin
               hr_addr  = PosW'(lc_w);
               state_in = S_DNWT;
            end
         end
         S_DNWT: begin
            // take the left child, read the right one
            lprio_in = hr_prio; lkey_in = hr_key;
            hr_addr  = PosW'(rc_w);
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (rc_w < (CntW+1)'(count_ff) && hr_prio > mprio_ff &&
                !(lprio_ff > mprio_ff && lprio_ff >= hr_prio)) begin
               hw_en = 1'b1; hw_prio = hr_prio; hw_key = hr_key;
               kp_we = 1'b1; kp_waddr = hr_key; kp_wdata = pos_ff;
               pos_in = PosW'(rc_w);
               state_in = S_DNRD;
            end else if (lprio_ff > mprio_ff) begin
               hw_en = 1'b1; hw_prio = lprio_ff; hw_key = lkey_ff;
               kp_we = 1'b1; kp_waddr = lkey_ff; kp_wdata = pos_ff;
               pos_in = PosW'(lc_w);
               state_in = S_DNRD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // drop moving entry at its final place
            hw_en = 1'b1; kp_we = 1'b1;
            state_in = S_ROOTRD;
         end
         S_ROOTRD: begin
            hr_addr = '0;
            state_in = S_ROOTWT;
         end
         S_ROOTWT: begin
            tkey_in = hr_key; tprio_in = hr_prio;
            done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy         = (state_ff != S_IDLE);
   assign status       = status_ff;
   assign top_key      = tkey_in;
   assign top_priority = tprio_in;
   assign count        = count_ff;
endmodule

>>> rtl/indexed_max_heap_top.sv
`timescale 1ns / 1ps
// channel | ports                                        | direction
// req     | req_valid/req_ready, op, key_id, new_priority | in
// rsp     | rsp_valid/rsp_ready, status..entry_total      | out
// csr     | csr_valid/csr_ready, csr_entry_limit          | in
// Refused words, clear and unknown ops skip the walk and only read the root;
// a push climbs and an update looks up its position, climbs, then descends,
// one level per step, since each step waits on the shared registered read
// port of the heap stores. Reset is synchronous; the count clears and the
// limit returns to 1024. The result sits in an output register; req_ready
// stays low while an item is in work or its result is not yet taken.
module indexed_max_heap_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [imh_pkg::PosW-1:0]    req_key_id,
   input  logic [imh_pkg::PrioW-1:0]   req_new_priority,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_heap_empty,
   output logic [imh_pkg::PosW-1:0]    rsp_top_key,
   output logic [imh_pkg::PrioW-1:0]   rsp_top_priority,
   output logic [imh_pkg::CntW-1:0]    rsp_entry_total,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [imh_pkg::CntW-1:0]    csr_entry_limit
);
   import imh_pkg::*;
`include "indexed_max_heap_top_assert.svh"

   logic [CntW-1:0]  limit_ff;
   logic             rsp_valid_ff;
   logic             busy, done, start;
   logic [1:0]       e_status;
   logic [PosW-1:0]  e_key;
   logic [PrioW-1:0] e_prio;
   logic [CntW-1:0]  e_count;
   logic [1:0]       status_ff;
   logic [PosW-1:0]  key_ff;
   logic [PrioW-1:0] prio_ff;
   logic [CntW-1:0]  total_ff;

   assign req_ready = !busy && !rsp_valid_ff;
   assign start     = req_valid && req_ready;
   assign csr_ready = 1'b1;

   imh_engine u_engine (
      .clock(clock), .reset(reset), .start(start), .op(req_op),
      .key_id(req_key_id), .new_priority(req_new_priority), .limit(limit_ff),
      .busy(busy), .done(done), .status(e_status), .top_key(e_key),
      .top_priority(e_prio), .count(e_count));

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= CntW'(MaxEntries);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_entry_limit;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (done) begin
         status_ff <= e_status;
         key_ff    <= e_key;
         prio_ff   <= e_prio;
         total_ff  <= e_count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_heap_empty   = (total_ff == '0);
   assign rsp_top_key      = (total_ff == '0) ? '0 : key_ff;
   assign rsp_top_priority = (total_ff == '0) ? '0 : prio_ff;
   assign rsp_entry_total  = total_ff;

   `IMH_ASSERT_IMP(a_no_start_busy, clock, reset, start, !busy && !rsp_valid_ff, "start while busy")
   `IMH_ASSERT_IMP(a_done_clear, clock, reset, done, !rsp_valid_ff, "result overrun")
   `IMH_ASSERT_NEXT(a_done_valid, clock, reset, done, rsp_valid, "result lost")
   `IMH_ASSERT_IMP(a_count_lim, clock, reset, rsp_valid, rsp_entry_total <= CntW'(MaxEntries), "count overflow")
endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import imh_pkg::*;

   localparam logic [1:0] OpReserved = 2'd3;

   typedef struct packed {
      logic [1:0]        status;
      logic              heap_empty;
      logic [PosW-1:0]   top_key;
      logic [PrioW-1:0]  top_priority;
      logic [CntW-1:0]   entry_total;
   } heap_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_op = OpPush;
   logic [PosW-1:0]   req_key_id = '0;
   logic [PrioW-1:0]  req_new_priority = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_status;
   logic              rsp_heap_empty;
   logic [PosW-1:0]   rsp_top_key;
   logic [PrioW-1:0]  rsp_top_priority;
   logic [CntW-1:0]   rsp_entry_total;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CntW-1:0]   csr_entry_limit = '0;

   indexed_max_heap_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_key_id(req_key_id), .req_new_priority(req_new_priority),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_heap_empty(rsp_heap_empty), .rsp_top_key(rsp_top_key),
      .rsp_top_priority(rsp_top_priority), .rsp_entry_total(rsp_entry_total),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_entry_limit(csr_entry_limit)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow heap
   logic [PrioW-1:0] sh_prio [MaxEntries];
   logic [PosW-1:0]  sh_key  [MaxEntries];
   int unsigned      sh_pos  [MaxEntries];
   int unsigned      sh_count;
   int unsigned      sh_limit;

   heap_word_type expected_words[$];
   int  mismatches;
   int  words_seen;
   int  items_sent;
   int  cycle_count = 0;
   bit  hold_rsp;
   bit  quiet_rsp;
   int  full_refusals, absent_hits;

   task automatic swap_entries(int unsigned a, int unsigned b);
      logic [PrioW-1:0] p;
      logic [PosW-1:0]  k;
      p = sh_prio[a]; k = sh_key[a];
      sh_prio[a] = sh_prio[b]; sh_key[a] = sh_key[b];
      sh_prio[b] = p; sh_key[b] = k;
      sh_pos[sh_key[a]] = a;
      sh_pos[sh_key[b]] = b;
   endtask

   function automatic int unsigned limit_now();
      return (sh_limit < MaxEntries) ? sh_limit : MaxEntries;
   endfunction

   task automatic predict_heap(logic [1:0] op, logic [PosW-1:0] key,
                               logic [PrioW-1:0] prio);
      heap_word_type w;
      int unsigned pos, par, lc, rc, best;
      logic [PrioW-1:0] bestv;
      w = '0;
      w.status = StOk;
      if (op == OpPush) begin
         if (sh_count >= limit_now()) begin
            w.status = StFull;
            full_refusals++;
         end else begin
            pos = sh_count;
            sh_prio[pos] = prio; sh_key[pos] = pos[PosW-1:0]; sh_pos[pos] = pos;
            // walk all the way to the root, no early exit
            while (pos > 0) begin
               par = (pos - 1) / 2;
               if (sh_prio[par] < sh_prio[pos]) swap_entries(par, pos);
               pos = par;
            end
            sh_count++;
         end
      end else if (op == OpUpdate) begin
         if (key >= sh_count || sh_pos[key] >= sh_count) begin
            w.status = StAbsent;
            absent_hits++;
         end else begin
            pos = sh_pos[key];
            sh_prio[pos] = prio;
            while (pos > 0) begin
               par = (pos - 1) / 2;
               if (prio <= sh_prio[par]) break;
               swap_entries(par, pos);
               pos = par;
            end
            while (pos < sh_count) begin
               lc = 2 * pos + 1; rc = 2 * pos + 2;
               best = pos; bestv = sh_prio[pos];
               if (lc < sh_count && sh_prio[lc] > bestv) begin
                  best = lc; bestv = sh_prio[lc];
               end
               if (rc < sh_count && sh_prio[rc] > bestv) best = rc;
               if (best == pos) break;
               swap_entries(pos, best);
               pos = best;
            end
         end
      end else if (op == OpClear) begin
         sh_count = 0;
      end
      if (sh_count == 0) begin
         w.heap_empty = 1'b1;
      end else begin
         w.top_key = sh_key[0];
         w.top_priority = sh_prio[0];
      end
      w.entry_total = sh_count[CntW-1:0];
      expected_words.insert(expected_words.size(), w);
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_rsp) return 0;
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // valid stays up between back-to-back words; drop it only for a gap
   task automatic send_item(logic [1:0] op, logic [PosW-1:0] key, logic [PrioW-1:0] prio);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op; req_key_id <= key; req_new_priority <= prio;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_heap(op, key, prio);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      // allow a full-depth walk to settle
      repeat (120) @(negedge clock);
   endtask

   task automatic write_limit(int unsigned value);
      drain();
      csr_valid <= 1'b1;
      csr_entry_limit <= value[CntW-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sh_limit = value & 11'h7FF;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [PrioW-1:0] rand_prio();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 7);    // lots of ties
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [PosW-1:0] rand_key();
      if (sh_count != 0 && $urandom_range(0, 9) < 8)
         return PosW'($urandom_range(0, sh_count - 1));
      return PosW'($urandom());
   endfunction

   // response side: random stalls
   always @(negedge clock) begin
      if (hold_rsp || (!quiet_rsp && $urandom_range(0, 99) < 30))
         rsp_ready <= 1'b0;
      else
         rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      heap_word_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status, rsp_heap_empty, rsp_top_key, rsp_top_priority, rsp_entry_total};
         words_seen++;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", got);
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch word %0d: expected %p actual %p", words_seen, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > 3000000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(OpUpdate, 10'd0, 32'h1);           // absent on empty heap
      send_item(OpPush, 10'h3FF, 32'h0);
      send_item(OpPush, 10'h155, 32'hFFFF_FFFF);
      send_item(OpPush, 10'h2AA, 32'hFFFF_FFFF);   // tie stays under root
      send_item(OpPush, 10'd0, 32'h8000_0000);
      send_item(OpPush, 10'd0, 32'h0001_0000);
      send_item(OpUpdate, 10'd1, 32'h0);           // sift down
      send_item(OpUpdate, 10'd0, 32'hFFFF_FFFF);   // sift up, ties stop
      send_item(OpUpdate, 10'd4, 32'h5555_AAAA);
      send_item(OpUpdate, 10'd5, 32'h1);           // absent
      send_item(OpUpdate, 10'h3FF, 32'h1);         // absent, top key bits
      send_item(OpReserved, 10'h2AA, 32'hAAAA_5555);
      send_item(OpClear, 10'h155, 32'h0);
      send_item(OpUpdate, 10'd0, 32'h1);           // absent after clear
      send_item(OpPush, 10'd0, 32'h7);
   endtask

   task automatic test_limits();
      write_limit(1);
      send_item(OpPush, 10'd0, 32'h1);             // count already 1: full
      send_item(OpClear, 10'd0, 32'h0);
      send_item(OpPush, 10'd0, 32'h2);
      send_item(OpPush, 10'd0, 32'h3);
      write_limit(0);
      send_item(OpClear, 10'd0, 32'h0);
      send_item(OpPush, 10'd0, 32'h3);
      write_limit(11'h7FF);                        // above capacity clamps
      send_item(OpClear, 10'd0, 32'h0);
   endtask

   task automatic test_random(int n, int unsigned limit);
      int r;
      write_limit(limit);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 2) send_item(OpClear, PosW'($urandom()), $urandom());
         else if (r < 3) send_item(OpReserved, PosW'($urandom()), $urandom());
         else if (r < 50) send_item(OpPush, PosW'($urandom()), rand_prio());
         else send_item(OpUpdate, rand_key(), rand_prio());
      end
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 20; i++) send_item(OpPush, PosW'($urandom()), rand_prio());
      join
   endtask

   task automatic test_fill();
      // small limit so the heap hits full often
      write_limit(6);
      send_item(OpClear, 10'd0, 32'h0);
      for (int i = 0; i < 60; i++)
         send_item($urandom_range(0, 2) == 0 ? OpUpdate : OpPush, rand_key(), rand_prio());
   endtask

   task automatic test_deep();
      // grow a deep heap, then update keys across it
      write_limit(1024);
      send_item(OpClear, 10'd0, 32'h0);
      quiet_rsp = 1'b1;
      for (int i = 0; i < 320; i++) send_item(OpPush, 10'd0, $urandom());
      quiet_rsp = 1'b0;
      for (int i = 0; i < 30; i++) send_item(OpUpdate, PosW'($urandom()), rand_prio());
   endtask

   initial begin
      hold_rsp = 1'b0; quiet_rsp = 1'b0;
      mismatches = 0; words_seen = 0; items_sent = 0;
      full_refusals = 0; absent_hits = 0;
      sh_count = 0; sh_limit = 1024;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_limits();
      test_backpressure();
      test_fill();
      test_random(310, 40);
      test_random(310, 300);
      test_deep();
      write_limit(1024);
      drain();
      $display("%0d items, %0d words checked, %0d full refusals, %0d absent-key updates",
               items_sent, words_seen, full_refusals, absent_hits);
      $display("limits 0, 1, 6, 40, 300, 1024, 2047; long result stall; heap grown past 300");
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d words missing", mismatches, expected_words.size());
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

>>> files.f
+incdir+rtl
rtl/imh_pkg.sv
rtl/imh_ram.sv
rtl/imh_engine.sv
rtl/indexed_max_heap_top.sv
test/tb_top.sv
